[rtl/cfp_pkg.sv]
// cfp_pkg: item types, status codes and register indexes for the
// command frame parser; no dependencies
package cfp_pkg;

  localparam int unsigned CfgIdxW     = 8;
  localparam int unsigned CfgDataW    = 16;
  localparam int unsigned QueueDepthD = 4;
  localparam int unsigned PosW        = 9;

  localparam logic [CfgIdxW-1:0] CfgIdxIdent = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgIdxCap   = CfgIdxW'(1);

  localparam logic [7:0]      CapReset = 8'd253;
  localparam logic [PosW-1:0] PosMax   = {PosW{1'b1}};
  localparam logic [PosW-1:0] PosLen   = PosW'(4);
  localparam logic [PosW-1:0] PosCodeH = PosW'(5);
  localparam logic [PosW-1:0] PosParam = PosW'(7);

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StShort    = 3'd1,
    StBadIdent = 3'd2,
    StBadSum   = 3'd3,
    StOverCap  = 3'd4,
    StBadLen   = 3'd5
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        is_status;
    logic [7:0]  param_byte;
    logic [7:0]  param_index;
    logic [7:0]  frame_type;
    logic [7:0]  frame_seq;
    logic [15:0] command_code;
    logic [7:0]  param_count;
    status_e     status;
  } out_item_t;

  typedef struct packed {
    logic [15:0] frame_identifier;
    logic [7:0]  param_capacity;
  } cfg_t;

endpackage

[rtl/command_frame_parser.sv]
// command_frame_parser: top level with configuration registers, parser
// front and result queue; depends on cfp_pkg, cfp_front, cfp_queue
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid_i/in_stall_o | in_item_i (in_item_t)
//   out     | output    | out_valid_o/out_stall_i | out_item_o (out_item_t)
//   cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// one byte item per cycle while in_stall_o is low; a result enters the queue in the
// cycle its byte is taken and can leave on the next cycle
// in_stall_o rises only while the QueueDepth-entry queue is full
// reset clears frame state and sets registers to their reset values
// cfg writes are always ready
module command_frame_parser
  import cfp_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthD
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t      cfg_q;
  logic      take;
  logic      res_valid;
  out_item_t res;
  logic      full;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = full;
  assign take        = in_valid_i && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_identifier <= '0;
      cfg_q.param_capacity   <= CapReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgIdxIdent: cfg_q.frame_identifier <= cfg_data_i;
        CfgIdxCap:   cfg_q.param_capacity   <= cfg_data_i[7:0];
        default:     ;
      endcase
    end
  end

  cfp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .take_i      (take),
    .item_i      (in_item_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  cfp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (take && res_valid),
    .push_item_i (res),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

[rtl/cfp_front.sv]
// cfp_front: byte-level frame parser that classifies each item and
// builds results for in-capacity parameter bytes and frame ends; depends on cfp_pkg
module cfp_front
  import cfp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      take_i,
  input  in_item_t  item_i,
  output logic      res_valid_o,
  output out_item_t res_o
);

  logic [PosW-1:0] pos_q, pos_d;
  logic [7:0]      sum_q, sum_d;
  logic [7:0]      idh_q, idh_d;
  logic            mis_q, mis_d;
  logic [7:0]      type_q, type_d;
  logic [7:0]      seq_q, seq_d;
  logic [7:0]      plen_q, plen_d;
  logic [15:0]     code_q, code_d;
  logic            fin_q, fin_d;

  logic            param_here;
  logic            len_ok;
  logic            cap_ok;
  logic [7:0]      pcount;
  logic [PosW:0]   chk_pos;
  status_e         st;

  assign chk_pos = (PosW+1)'(PosCodeH) + (PosW+1)'(plen_q);

  always_comb begin
    sum_d      = sum_q;
    idh_d      = idh_q;
    mis_d      = mis_q;
    type_d     = type_q;
    seq_d      = seq_q;
    plen_d     = plen_q;
    code_d     = code_q;
    fin_d      = fin_q;
    param_here = 1'b0;
    if (!fin_q) begin
      if (pos_q >= PosCodeH && {1'b0, pos_q} == chk_pos) begin
        sum_d = sum_q - item_i.data_byte;
        fin_d = 1'b1;
      end else begin
        sum_d = sum_q + item_i.data_byte;
        case (pos_q)
          PosW'(0): idh_d  = item_i.data_byte;
          PosW'(1): mis_d  = ({idh_q, item_i.data_byte} != cfg_i.frame_identifier);
          PosW'(2): type_d = item_i.data_byte;
          PosW'(3): seq_d  = item_i.data_byte;
          PosLen:   plen_d = item_i.data_byte;
          PosCodeH: code_d = {item_i.data_byte, code_q[7:0]};
          PosW'(6): code_d = {code_q[15:8], item_i.data_byte};
          default:  param_here = 1'b1;
        endcase
      end
    end
    pos_d = (pos_q == PosMax) ? pos_q : pos_q + PosW'(1);
  end

  assign len_ok = (plen_d >= 8'd2);
  assign pcount = plen_d - 8'd2;
  assign cap_ok = len_ok && (pcount <= cfg_i.param_capacity);

  always_comb begin
    if (pos_q < PosParam) begin
      st = StShort;
    end else if (mis_d) begin
      st = StBadIdent;
    end else if (!fin_d) begin
      st = StShort;
    end else if (sum_d != 8'd0) begin
      st = StBadSum;
    end else if (!len_ok) begin
      st = StBadLen;
    end else if (!cap_ok) begin
      st = StOverCap;
    end else begin
      st = StOk;
    end
  end

  always_comb begin
    res_o = '0;
    res_valid_o = 1'b0;
    if (item_i.last_byte) begin
      res_valid_o     = 1'b1;
      res_o.is_status = 1'b1;
      res_o.status    = st;
      if (st == StOk) begin
        res_o.frame_type   = type_d;
        res_o.frame_seq    = seq_d;
        res_o.command_code = code_d;
        res_o.param_count  = pcount;
      end
    end else if (param_here && cap_ok) begin
      res_valid_o       = 1'b1;
      res_o.param_byte  = item_i.data_byte;
      res_o.param_index = 8'(pos_q - PosParam);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      sum_q  <= '0;
      idh_q  <= '0;
      mis_q  <= 1'b0;
      type_q <= '0;
      seq_q  <= '0;
      plen_q <= '0;
      code_q <= '0;
      fin_q  <= 1'b0;
    end else if (take_i) begin
      if (item_i.last_byte) begin
        pos_q  <= '0;
        sum_q  <= '0;
        idh_q  <= '0;
        mis_q  <= 1'b0;
        type_q <= '0;
        seq_q  <= '0;
        plen_q <= '0;
        code_q <= '0;
        fin_q  <= 1'b0;
      end else begin
        pos_q  <= pos_d;
        sum_q  <= sum_d;
        idh_q  <= idh_d;
        mis_q  <= mis_d;
        type_q <= type_d;
        seq_q  <= seq_d;
        plen_q <= plen_d;
        code_q <= code_d;
        fin_q  <= fin_d;
      end
    end
  end

endmodule

[rtl/cfp_queue.sv]
// cfp_queue: short result queue between parser and output side;
// depends on cfp_pkg
module cfp_queue
  import cfp_pkg::*;
#(
  parameter int unsigned Depth = QueueDepthD
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  out_item_t push_item_i,
  output logic      full_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  out_item_t       mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;

  assign full_o      = (cnt_q == FullCnt);
  assign out_valid_o = (cnt_q != '0);
  assign out_item_o  = mem_q[rd_q];
  assign pop         = out_valid_o && !out_stall_i;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
    end
    if (pop) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
    end
    case ({push_i, pop})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule
